// File: rtl/ljpfa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the 12-6 pair force accumulator.
// Used by every module of the block; depends on nothing.

package ljpfa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = 31;
    localparam int POS_W     = 32;
    localparam int OUT_W     = 48;
    localparam int MAG_W     = 31;                 // separation magnitude kept after range check
    localparam int SEP_W     = 36;                 // wrapped separation, signed
    localparam int SQ_W      = 2 * MAG_W;
    localparam int R2_W      = SQ_W + 1;
    localparam int MUL_W     = 62;                 // multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;
    localparam int PROD_LIM  = 64;                 // products at or above 2^64 cap
    localparam int RES_W     = 61;                 // capped product, at most 2^60
    localparam int DIV_W     = 2 * FRAC_BITS + 1;  // quotient bits of 2^(2F) / r2q
    localparam int DCNT_W    = $clog2(DIV_W);
    localparam int MCNT_W    = $clog2(MUL_W + 1);
    localparam int CORE_W    = RES_W + 2;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int NSTAGE    = 5;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_SCALE = 2'd2;

    localparam logic [CFG_W-1:0] BOX_RST = 31'd2270233;
    localparam logic [CFG_W-1:0] CUT_RST = 31'd409600;
    localparam logic [CFG_W-1:0] EPS_RST = 31'd65536;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic [RES_W-1:0] CAP_VAL = {1'b1, {(RES_W-1){1'b0}}};

    typedef struct packed {
        logic             hit;
        logic             last;
        logic             sx;
        logic             sy;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
        logic [MAG_W-1:0] r2q;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] res;
    } mul_rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL_GO,
        BK_MUL_WAIT,
        BK_ACC
    } bk_state_t;

    typedef enum logic [3:0] {
        OP_SQ,
        OP_CUBE,
        OP_INV12,
        OP_G,
        OP_FMAG,
        OP_PFX,
        OP_PFY,
        OP_VIR,
        OP_PEN
    } op_t;

    // subtract the box once when the separation exceeds half of it
    function automatic logic signed [SEP_W-1:0] wrap_hi(input logic signed [SEP_W-1:0] d,
                                                         input logic [CFG_W-1:0] len);
        logic signed [SEP_W:0] twice;
        logic signed [SEP_W:0] lext;
        twice = {d, 1'b0};
        lext  = $signed({{(SEP_W+1-CFG_W){1'b0}}, len});
        return (twice > lext) ? d - $signed({{(SEP_W-CFG_W){1'b0}}, len}) : d;
    endfunction

    function automatic logic signed [SEP_W-1:0] wrap_lo(input logic signed [SEP_W-1:0] d,
                                                         input logic [CFG_W-1:0] len);
        logic signed [SEP_W:0] twice;
        logic signed [SEP_W:0] lext;
        twice = {d, 1'b0};
        lext  = $signed({{(SEP_W+1-CFG_W){1'b0}}, len});
        return (twice < -lext) ? d + $signed({{(SEP_W-CFG_W){1'b0}}, len}) : d;
    endfunction

    // apply sign to a capped magnitude and clamp to the output width
    function automatic logic [OUT_W-1:0] sat_mag(input logic [RES_W-1:0] mag, input logic neg);
        logic [OUT_W-1:0] r;
        if (!neg)
        begin
            r = (mag > RES_W'(OUT_MAX)) ? OUT_MAX : mag[OUT_W-1:0];
        end
        else
        begin
            r = (mag > RES_W'(OUT_MIN)) ? OUT_MIN : OUT_W'(-mag[OUT_W-1:0]);
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] sat_add(input logic [OUT_W-1:0] a,
                                                 input logic [OUT_W-1:0] b);
        logic [OUT_W:0]   s;
        logic [OUT_W-1:0] r;
        s = {a[OUT_W-1], a} + {b[OUT_W-1], b};
        if (s[OUT_W] != s[OUT_W-1])
        begin
            r = s[OUT_W] ? OUT_MIN : OUT_MAX;
        end
        else
        begin
            r = s[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/lj_pair_force_accumulator.sv
`timescale 1ns / 1ps
// Top level of the 12-6 pair force accumulator: configuration registers,
// front pipe, queue and back sequencer. Depends on ljpfa_pkg and all ljpfa_* modules.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | input     | in_valid/in_stall   | xi yi xj yj skip_pair last_pair
//  out     | output    | out_valid/out_stall | pair_*, in_range, total_*, done_res
//  cfg     | input     | cfg_wr_en           | cfg_index, cfg_data
//
// Pairs take a five-stage front pipe, then wait in a two-word queue for the back end.
// A skipped or out-of-range pair goes from the pop straight to the result load; a pair
// inside the cutoff is popped, then runs the bit-serial divide, nine passes on the shared
// 62-bit shift-add multiplier and the result load. Reset clears the pipe,
// queue, totals and loads the register defaults. A stalled output holds the result;
// the front keeps filling the queue.

module lj_pair_force_accumulator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [ljpfa_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ljpfa_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [ljpfa_pkg::POS_W-1:0]      xi,
    input  logic signed [ljpfa_pkg::POS_W-1:0]      yi,
    input  logic signed [ljpfa_pkg::POS_W-1:0]      xj,
    input  logic signed [ljpfa_pkg::POS_W-1:0]      yj,
    input  logic                                    skip_pair,
    input  logic                                    last_pair,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [ljpfa_pkg::OUT_W-1:0]      pair_fx,
    output logic signed [ljpfa_pkg::OUT_W-1:0]      pair_fy,
    output logic signed [ljpfa_pkg::OUT_W-1:0]      pair_vir,
    output logic signed [ljpfa_pkg::OUT_W-1:0]      pair_energy,
    output logic                                    in_range,
    output logic signed [ljpfa_pkg::OUT_W-1:0]      total_fx,
    output logic signed [ljpfa_pkg::OUT_W-1:0]      total_fy,
    output logic signed [ljpfa_pkg::OUT_W-1:0]      total_virial,
    output logic signed [ljpfa_pkg::OUT_W-1:0]      total_energy,
    output logic                                    done_res
);

    logic [ljpfa_pkg::CFG_W-1:0] box_reg, cut_reg, eps_reg;
    logic                        q_push, q_pop, q_full, q_empty;
    ljpfa_pkg::item_t            q_wdata, q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= ljpfa_pkg::BOX_RST;
            cut_reg <= ljpfa_pkg::CUT_RST;
            eps_reg <= ljpfa_pkg::EPS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ljpfa_pkg::CFG_BOX_LENGTH:   box_reg <= cfg_data;
                ljpfa_pkg::CFG_CUTOFF_SQ:    cut_reg <= cfg_data;
                ljpfa_pkg::CFG_ENERGY_SCALE: eps_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    ljpfa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .xi         (xi),
        .yi         (yi),
        .xj         (xj),
        .yj         (yj),
        .skip_pair  (skip_pair),
        .last_pair  (last_pair),
        .box_length (box_reg),
        .cutoff_sq  (cut_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_wdata)
    );

    ljpfa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    ljpfa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .energy_scale (eps_reg),
        .q_empty      (q_empty),
        .q_item       (q_rdata),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pair_fx      (pair_fx),
        .pair_fy      (pair_fy),
        .pair_vir     (pair_vir),
        .pair_energy  (pair_energy),
        .in_range     (in_range),
        .total_fx     (total_fx),
        .total_fy     (total_fy),
        .total_virial (total_virial),
        .total_energy (total_energy),
        .done_res     (done_res)
    );

endmodule

// File: rtl/ljpfa_front.sv
`timescale 1ns / 1ps
// Front pipeline: separation, periodic wrap, squared distance and cutoff test.
// Depends on ljpfa_pkg; pushes classified words into ljpfa_queue.

module ljpfa_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [ljpfa_pkg::POS_W-1:0] xi,
    input  logic signed [ljpfa_pkg::POS_W-1:0] yi,
    input  logic signed [ljpfa_pkg::POS_W-1:0] xj,
    input  logic signed [ljpfa_pkg::POS_W-1:0] yj,
    input  logic                           skip_pair,
    input  logic                           last_pair,
    input  logic [ljpfa_pkg::CFG_W-1:0]    box_length,
    input  logic [ljpfa_pkg::CFG_W-1:0]    cutoff_sq,
    input  logic                           q_full,
    output logic                           q_push,
    output ljpfa_pkg::item_t               q_item
);

    logic [ljpfa_pkg::NSTAGE-1:0] vld_reg;
    logic [ljpfa_pkg::NSTAGE-1:0] skip_reg;
    logic [ljpfa_pkg::NSTAGE-1:0] last_reg;
    logic                         advance;

    logic signed [ljpfa_pkg::SEP_W-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic [ljpfa_pkg::SEP_W-1:0]        mx, my;
    logic [ljpfa_pkg::MAG_W-1:0]        ax4_reg, ay4_reg, ax5_reg, ay5_reg;
    logic                               sx4_reg, sy4_reg, sx5_reg, sy5_reg;
    logic                               big4_reg, big5_reg;
    logic [ljpfa_pkg::SQ_W-1:0]         sqx5_reg, sqy5_reg;
    logic [ljpfa_pkg::R2_W-1:0]         r2, r2_lim;
    logic [ljpfa_pkg::MAG_W-1:0]        r2q;

    // the whole pipe moves together; hold when the last stage cannot push
    assign advance  = !(vld_reg[ljpfa_pkg::NSTAGE-1] && q_full);
    assign in_stall = !advance;
    assign q_push   = vld_reg[ljpfa_pkg::NSTAGE-1] && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[ljpfa_pkg::NSTAGE-2:0], in_valid};
        end
    end

    assign mx = dx3_reg[ljpfa_pkg::SEP_W-1] ? ljpfa_pkg::SEP_W'(-dx3_reg) : dx3_reg;
    assign my = dy3_reg[ljpfa_pkg::SEP_W-1] ? ljpfa_pkg::SEP_W'(-dy3_reg) : dy3_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            skip_reg <= {skip_reg[ljpfa_pkg::NSTAGE-2:0], skip_pair};
            last_reg <= {last_reg[ljpfa_pkg::NSTAGE-2:0], last_pair};
            dx1_reg  <= ljpfa_pkg::SEP_W'(xi) - ljpfa_pkg::SEP_W'(xj);
            dy1_reg  <= ljpfa_pkg::SEP_W'(yi) - ljpfa_pkg::SEP_W'(yj);
            dx2_reg  <= ljpfa_pkg::wrap_hi(dx1_reg, box_length);
            dy2_reg  <= ljpfa_pkg::wrap_hi(dy1_reg, box_length);
            dx3_reg  <= ljpfa_pkg::wrap_lo(dx2_reg, box_length);
            dy3_reg  <= ljpfa_pkg::wrap_lo(dy2_reg, box_length);
            ax4_reg  <= mx[ljpfa_pkg::MAG_W-1:0];
            ay4_reg  <= my[ljpfa_pkg::MAG_W-1:0];
            sx4_reg  <= dx3_reg[ljpfa_pkg::SEP_W-1];
            sy4_reg  <= dy3_reg[ljpfa_pkg::SEP_W-1];
            big4_reg <= (|mx[ljpfa_pkg::SEP_W-1:ljpfa_pkg::MAG_W])
                        || (|my[ljpfa_pkg::SEP_W-1:ljpfa_pkg::MAG_W]);
            ax5_reg  <= ax4_reg;
            ay5_reg  <= ay4_reg;
            sx5_reg  <= sx4_reg;
            sy5_reg  <= sy4_reg;
            big5_reg <= big4_reg;
            sqx5_reg <= ljpfa_pkg::SQ_W'(ax4_reg) * ljpfa_pkg::SQ_W'(ax4_reg);
            sqy5_reg <= ljpfa_pkg::SQ_W'(ay4_reg) * ljpfa_pkg::SQ_W'(ay4_reg);
        end
    end

    always_comb
    begin
        r2     = ljpfa_pkg::R2_W'(sqx5_reg) + ljpfa_pkg::R2_W'(sqy5_reg);
        r2_lim = ljpfa_pkg::R2_W'(cutoff_sq) << ljpfa_pkg::FRAC_BITS;
        r2q    = r2[ljpfa_pkg::FRAC_BITS +: ljpfa_pkg::MAG_W];
        if (r2q == '0)
        begin
            r2q = ljpfa_pkg::MAG_W'(1);
        end
        q_item.hit  = !skip_reg[ljpfa_pkg::NSTAGE-1] && !big5_reg && (r2 != '0) && (r2 < r2_lim);
        q_item.last = last_reg[ljpfa_pkg::NSTAGE-1];
        q_item.sx   = sx5_reg;
        q_item.sy   = sy5_reg;
        q_item.ax   = ax5_reg;
        q_item.ay   = ay5_reg;
        q_item.r2q  = r2q;
    end

endmodule

// File: rtl/ljpfa_queue.sv
`timescale 1ns / 1ps
// Short queue of classified pair words between the front pipe and the back sequencer.
// Depends on ljpfa_pkg.

module ljpfa_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ljpfa_pkg::item_t wdata,
    output logic             full,
    input  logic             pop,
    output ljpfa_pkg::item_t rdata,
    output logic             empty
);

    ljpfa_pkg::item_t                mem_reg [ljpfa_pkg::QDEPTH];
    logic [ljpfa_pkg::QPTR_W-1:0]    wptr_reg, rptr_reg;
    logic [ljpfa_pkg::QCNT_W-1:0]    cnt_reg;

    assign full  = (cnt_reg == ljpfa_pkg::QCNT_W'(ljpfa_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/ljpfa_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier, one operand bit per cycle, with product scaling and cap.
// Depends on ljpfa_pkg.

module ljpfa_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  ljpfa_pkg::mul_req_t req,
    output ljpfa_pkg::mul_rsp_t rsp
);

    logic [ljpfa_pkg::MUL_W-1:0]  a_reg, b_reg;
    logic [ljpfa_pkg::PROD_W-1:0] acc_reg;
    logic [ljpfa_pkg::MCNT_W-1:0] cnt_reg;
    logic                         done_reg;
    logic [ljpfa_pkg::MUL_W:0]    sum;

    assign sum = {1'b0, acc_reg[ljpfa_pkg::PROD_W-1:ljpfa_pkg::MUL_W]}
               + (b_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == ljpfa_pkg::MCNT_W'(1));
            if (req.start)
            begin
                cnt_reg <= ljpfa_pkg::MCNT_W'(ljpfa_pkg::MUL_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= {sum, acc_reg[ljpfa_pkg::MUL_W-1:1]};
            b_reg   <= b_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = (|acc_reg[ljpfa_pkg::PROD_W-1:ljpfa_pkg::PROD_LIM])
                    ? ljpfa_pkg::CAP_VAL
                    : ljpfa_pkg::RES_W'(acc_reg[ljpfa_pkg::PROD_LIM-1:ljpfa_pkg::FRAC_BITS]);

endmodule

// File: rtl/ljpfa_back.sv
`timescale 1ns / 1ps
// Back sequencer: reciprocal divide, power and force chain on the shared multiplier,
// running totals and the result register. Depends on ljpfa_pkg and ljpfa_mul.

module ljpfa_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ljpfa_pkg::CFG_W-1:0]         energy_scale,
    input  logic                                q_empty,
    input  ljpfa_pkg::item_t                    q_item,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [ljpfa_pkg::OUT_W-1:0]  pair_fx,
    output logic signed [ljpfa_pkg::OUT_W-1:0]  pair_fy,
    output logic signed [ljpfa_pkg::OUT_W-1:0]  pair_vir,
    output logic signed [ljpfa_pkg::OUT_W-1:0]  pair_energy,
    output logic                                in_range,
    output logic signed [ljpfa_pkg::OUT_W-1:0]  total_fx,
    output logic signed [ljpfa_pkg::OUT_W-1:0]  total_fy,
    output logic signed [ljpfa_pkg::OUT_W-1:0]  total_virial,
    output logic signed [ljpfa_pkg::OUT_W-1:0]  total_energy,
    output logic                                done_res
);

    localparam int OW = ljpfa_pkg::OUT_W;
    localparam int RW = ljpfa_pkg::RES_W;
    localparam int MW = ljpfa_pkg::MUL_W;
    localparam int MG = ljpfa_pkg::MAG_W;

    ljpfa_pkg::bk_state_t state_reg, state_next;
    ljpfa_pkg::op_t       op_reg, op_next;
    ljpfa_pkg::mul_req_t  mreq;
    ljpfa_pkg::mul_rsp_t  mrsp;
    logic                 mul_start;

    logic          hit_reg, hit_next, last_reg, last_next, sx_reg, sx_next, sy_reg, sy_next;
    logic [MG-1:0] ax_reg, ax_next, ay_reg, ay_next, r2q_reg, r2q_next;
    logic [MG-1:0] rem_reg, rem_next;
    logic [MG:0]   rem_sh;
    logic [ljpfa_pkg::DIV_W-1:0]  quot_reg, quot_next;
    logic [ljpfa_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic          qbit;
    logic [RW-1:0] t_reg, t_next, inv6_reg, inv6_next, inv12_reg, inv12_next;
    logic [RW-1:0] g_reg, g_next, fmag_reg, fmag_next;
    logic          fneg_reg, fneg_next;
    logic [OW-1:0] pfx_reg, pfx_next, pfy_reg, pfy_next, pvir_reg, pvir_next, pen_reg, pen_next;
    logic [OW-1:0] afx_reg, afx_next, afy_reg, afy_next, avir_reg, avir_next;
    logic [OW-1:0] aen_reg, aen_next;
    logic [OW-1:0] sfx, sfy, svir, sen;
    logic          out_valid_reg, out_valid_next;
    logic          load_out;
    logic signed [ljpfa_pkg::CORE_W-1:0] core_f, core_e;
    logic [ljpfa_pkg::CORE_W-1:0]        core_f_mag, core_e_mag;
    logic [MW-1:0] eps24, eps4;

    logic [OW-1:0] o_pfx_reg, o_pfy_reg, o_pvir_reg, o_pen_reg;
    logic [OW-1:0] o_tfx_reg, o_tfy_reg, o_tvir_reg, o_ten_reg;
    logic          o_hit_reg, o_done_reg;

    ljpfa_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign core_f     = $signed({1'b0, inv12_reg, 1'b0}) - $signed({2'b0, inv6_reg});
    assign core_e     = $signed({2'b0, inv12_reg}) - $signed({2'b0, inv6_reg});
    assign core_f_mag = core_f[ljpfa_pkg::CORE_W-1] ? ljpfa_pkg::CORE_W'(-core_f) : core_f;
    assign core_e_mag = core_e[ljpfa_pkg::CORE_W-1] ? ljpfa_pkg::CORE_W'(-core_e) : core_e;
    assign eps24      = (MW'(energy_scale) << 4) + (MW'(energy_scale) << 3);
    assign eps4       = MW'(energy_scale) << 2;

    // operand select for the current step of the force chain
    always_comb
    begin
        mreq.start = mul_start;
        mreq.a = MW'(quot_reg);
        mreq.b = MW'(quot_reg);
        case (op_reg)
            ljpfa_pkg::OP_SQ:
            begin
                mreq.a = MW'(quot_reg);
                mreq.b = MW'(quot_reg);
            end
            ljpfa_pkg::OP_CUBE:
            begin
                mreq.a = MW'(t_reg);
                mreq.b = MW'(quot_reg);
            end
            ljpfa_pkg::OP_INV12:
            begin
                mreq.a = MW'(inv6_reg);
                mreq.b = MW'(inv6_reg);
            end
            ljpfa_pkg::OP_G:
            begin
                mreq.a = eps24;
                mreq.b = MW'(quot_reg);
            end
            ljpfa_pkg::OP_FMAG:
            begin
                mreq.a = core_f_mag[MW-1:0];
                mreq.b = MW'(g_reg);
            end
            ljpfa_pkg::OP_PFX:
            begin
                mreq.a = MW'(ax_reg);
                mreq.b = MW'(fmag_reg);
            end
            ljpfa_pkg::OP_PFY:
            begin
                mreq.a = MW'(ay_reg);
                mreq.b = MW'(fmag_reg);
            end
            ljpfa_pkg::OP_VIR:
            begin
                mreq.a = MW'(fmag_reg);
                mreq.b = MW'(r2q_reg);
            end
            ljpfa_pkg::OP_PEN:
            begin
                mreq.a = core_e_mag[MW-1:0];
                mreq.b = eps4;
            end
            default:
            begin
                mreq.a = '0;
                mreq.b = '0;
            end
        endcase
    end

    always_comb
    begin
        sfx  = ljpfa_pkg::sat_add(afx_reg, pfx_reg);
        sfy  = ljpfa_pkg::sat_add(afy_reg, pfy_reg);
        svir = ljpfa_pkg::sat_add(avir_reg, pvir_reg);
        sen  = ljpfa_pkg::sat_add(aen_reg, pen_reg);
        rem_sh = {rem_reg, (cnt_reg == ljpfa_pkg::DCNT_W'(ljpfa_pkg::DIV_W - 1))};
        qbit   = (rem_sh >= {1'b0, r2q_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        hit_next   = hit_reg;
        last_next  = last_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        r2q_next   = r2q_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        t_next     = t_reg;
        inv6_next  = inv6_reg;
        inv12_next = inv12_reg;
        g_next     = g_reg;
        fmag_next  = fmag_reg;
        fneg_next  = fneg_reg;
        pfx_next   = pfx_reg;
        pfy_next   = pfy_reg;
        pvir_next  = pvir_reg;
        pen_next   = pen_reg;
        afx_next   = afx_reg;
        afy_next   = afy_reg;
        avir_next  = avir_reg;
        aen_next   = aen_reg;
        q_pop      = 1'b0;
        mul_start  = 1'b0;
        load_out   = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ljpfa_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    hit_next  = q_item.hit;
                    last_next = q_item.last;
                    sx_next   = q_item.sx;
                    sy_next   = q_item.sy;
                    ax_next   = q_item.ax;
                    ay_next   = q_item.ay;
                    r2q_next  = q_item.r2q;
                    pfx_next  = '0;
                    pfy_next  = '0;
                    pvir_next = '0;
                    pen_next  = '0;
                    rem_next  = '0;
                    quot_next = '0;
                    cnt_next  = ljpfa_pkg::DCNT_W'(ljpfa_pkg::DIV_W - 1);
                    state_next = q_item.hit ? ljpfa_pkg::BK_DIV : ljpfa_pkg::BK_ACC;
                end
            end
            ljpfa_pkg::BK_DIV:
            begin
                // one quotient bit of 2^(2F) / r2q per cycle
                rem_next  = qbit ? MG'(rem_sh - {1'b0, r2q_reg}) : rem_sh[MG-1:0];
                quot_next = {quot_reg[ljpfa_pkg::DIV_W-2:0], qbit};
                if (cnt_reg == '0)
                begin
                    op_next    = ljpfa_pkg::OP_SQ;
                    state_next = ljpfa_pkg::BK_MUL_GO;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ljpfa_pkg::BK_MUL_GO:
            begin
                mul_start  = 1'b1;
                state_next = ljpfa_pkg::BK_MUL_WAIT;
            end
            ljpfa_pkg::BK_MUL_WAIT:
            begin
                if (mrsp.done)
                begin
                    state_next = ljpfa_pkg::BK_MUL_GO;
                    case (op_reg)
                        ljpfa_pkg::OP_SQ:
                        begin
                            t_next  = mrsp.res;
                            op_next = ljpfa_pkg::OP_CUBE;
                        end
                        ljpfa_pkg::OP_CUBE:
                        begin
                            inv6_next = mrsp.res;
                            op_next   = ljpfa_pkg::OP_INV12;
                        end
                        ljpfa_pkg::OP_INV12:
                        begin
                            inv12_next = mrsp.res;
                            op_next    = ljpfa_pkg::OP_G;
                        end
                        ljpfa_pkg::OP_G:
                        begin
                            g_next  = mrsp.res;
                            op_next = ljpfa_pkg::OP_FMAG;
                        end
                        ljpfa_pkg::OP_FMAG:
                        begin
                            fmag_next = mrsp.res;
                            fneg_next = core_f[ljpfa_pkg::CORE_W-1];
                            op_next   = ljpfa_pkg::OP_PFX;
                        end
                        ljpfa_pkg::OP_PFX:
                        begin
                            pfx_next = ljpfa_pkg::sat_mag(mrsp.res, sx_reg ^ fneg_reg);
                            op_next  = ljpfa_pkg::OP_PFY;
                        end
                        ljpfa_pkg::OP_PFY:
                        begin
                            pfy_next = ljpfa_pkg::sat_mag(mrsp.res, sy_reg ^ fneg_reg);
                            op_next  = ljpfa_pkg::OP_VIR;
                        end
                        ljpfa_pkg::OP_VIR:
                        begin
                            pvir_next = ljpfa_pkg::sat_mag(mrsp.res, fneg_reg);
                            op_next   = ljpfa_pkg::OP_PEN;
                        end
                        ljpfa_pkg::OP_PEN:
                        begin
                            pen_next   = ljpfa_pkg::sat_mag(mrsp.res, core_e[ljpfa_pkg::CORE_W-1]);
                            state_next = ljpfa_pkg::BK_ACC;
                        end
                        default:
                        begin
                            state_next = ljpfa_pkg::BK_IDLE;
                        end
                    endcase
                end
            end
            ljpfa_pkg::BK_ACC:
            begin
                // hold until the result register is free
                if (!(out_valid_reg && out_stall))
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    afx_next  = last_reg ? '0 : sfx;
                    afy_next  = last_reg ? '0 : sfy;
                    avir_next = last_reg ? '0 : svir;
                    aen_next  = last_reg ? '0 : sen;
                    state_next = ljpfa_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ljpfa_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ljpfa_pkg::BK_IDLE;
            op_reg        <= ljpfa_pkg::OP_SQ;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            afx_reg       <= '0;
            afy_reg       <= '0;
            avir_reg      <= '0;
            aen_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            afx_reg       <= afx_next;
            afy_reg       <= afy_next;
            avir_reg      <= avir_next;
            aen_reg       <= aen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg   <= hit_next;
        last_reg  <= last_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        r2q_reg   <= r2q_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        t_reg     <= t_next;
        inv6_reg  <= inv6_next;
        inv12_reg <= inv12_next;
        g_reg     <= g_next;
        fmag_reg  <= fmag_next;
        fneg_reg  <= fneg_next;
        pfx_reg   <= pfx_next;
        pfy_reg   <= pfy_next;
        pvir_reg  <= pvir_next;
        pen_reg   <= pen_next;
        if (load_out)
        begin
            o_pfx_reg  <= pfx_reg;
            o_pfy_reg  <= pfy_reg;
            o_pvir_reg <= pvir_reg;
            o_pen_reg  <= pen_reg;
            o_hit_reg  <= hit_reg;
            o_tfx_reg  <= sfx;
            o_tfy_reg  <= sfy;
            o_tvir_reg <= svir;
            o_ten_reg  <= sen;
            o_done_reg <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pair_fx      = o_pfx_reg;
    assign pair_fy      = o_pfy_reg;
    assign pair_vir     = o_pvir_reg;
    assign pair_energy  = o_pen_reg;
    assign in_range     = o_hit_reg;
    assign total_fx     = o_tfx_reg;
    assign total_fy     = o_tfy_reg;
    assign total_virial = o_tvir_reg;
    assign total_energy = o_ten_reg;
    assign done_res     = o_done_reg;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mrsp.done |-> state_reg == ljpfa_pkg::BK_MUL_WAIT)
        else $error("multiplier finished outside its wait state");

    a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ljpfa_pkg::BK_IDLE && !q_empty))
        else $error("queue popped while busy or empty");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ljpfa_pkg::BK_DIV |=>
            (state_reg == ljpfa_pkg::BK_DIV || state_reg == ljpfa_pkg::BK_MUL_GO))
        else $error("divide left to an unexpected state");

    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && last_reg) |=> (afx_reg == '0 && aen_reg == '0))
        else $error("totals not cleared after last pair");
`endif

endmodule
